>>> src/ray_box_slab_test_macros.svh
// ---------------------------------------------------------------------------
// ray_box_slab_test_macros
// assertion shorthands used by the checker file
// ---------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_TEST_MACROS_SVH
`define RAY_BOX_SLAB_TEST_MACROS_SVH

// same-cycle implication, checked off reset
`define RBST_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbst assertion failed");

// next-cycle implication, checked off reset
`define RBST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbst assertion failed");

`endif

>>> src/rbst_pkg.sv
// ---------------------------------------------------------------------------
// rbst_pkg
// widths, constants and shared types of the ray/box slab test
// ---------------------------------------------------------------------------
package rbst_pkg;

    localparam int DATA_W  = 32;
    localparam int DIFF_W  = DATA_W + 1;
    localparam int T_W     = 64;
    localparam int THR_W   = 31;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam int DEPTH   = 5;

    localparam logic [PADDR_W-1:0] THR_ADDR  = 2'd0;
    localparam logic [THR_W-1:0]   THR_RESET = 31'h4000_0000;

    localparam logic [T_W-1:0] T_NEG_INF = {1'b1, {(T_W-1){1'b0}}};
    localparam logic [T_W-1:0] T_POS_INF = {1'b0, {(T_W-1){1'b1}}};

    // one axis of the incoming ray/box pair
    typedef struct packed {
        logic [DATA_W-1:0] org;
        logic [DATA_W-1:0] rcp;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
    } rbst_axis_in_t;

    // slab interval of one axis
    typedef struct packed {
        logic [T_W-1:0] near_t;
        logic [T_W-1:0] far_t;
        logic           miss;
    } rbst_slab_t;

endpackage

>>> src/ray_box_slab_test.sv
// ---------------------------------------------------------------------------
// ray_box_slab_test
// ray against axis-aligned box, slab method, fixed point q16.16
// ---------------------------------------------------------------------------
// usage:
//   input channel in_valid / in_stall carries one ray/box pair per transfer:
//   origin, reciprocal direction and lower/upper bounds, three axes each.
//   output channel out_valid / out_stall carries one hit bit per pair.
//   the parallel threshold sits at apb address 0 and is to be written only
//   while idle; the user is bound to this, the block does not enforce it.
// pipeline: five register stages (differences, products, ordering, min/max,
//   decision) lie between the input transfer and the result.
// throughput: one pair per cycle unless held; all stages share one advance.
// stall: while out_valid is high and out_stall is high every stage holds,
//   and in_stall is raised; nothing is dropped or repeated.
// reset: rst_n clears all valid bits and loads the threshold with 2^30.
// ---------------------------------------------------------------------------
module ray_box_slab_test
    import rbst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [DATA_W-1:0]  origin_x,
    input  logic [DATA_W-1:0]  origin_y,
    input  logic [DATA_W-1:0]  origin_z,
    input  logic [DATA_W-1:0]  recip_x,
    input  logic [DATA_W-1:0]  recip_y,
    input  logic [DATA_W-1:0]  recip_z,
    input  logic [DATA_W-1:0]  lo_x,
    input  logic [DATA_W-1:0]  lo_y,
    input  logic [DATA_W-1:0]  lo_z,
    input  logic [DATA_W-1:0]  hi_x,
    input  logic [DATA_W-1:0]  hi_y,
    input  logic [DATA_W-1:0]  hi_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [THR_W-1:0] threshold;
    logic             en;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    rbst_axis_in_t    ax_x;
    rbst_axis_in_t    ax_y;
    rbst_axis_in_t    ax_z;
    rbst_slab_t       slab_x;
    rbst_slab_t       slab_y;
    rbst_slab_t       slab_z;

    rbst_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .threshold (threshold)
    );

    // whole pipe advances together unless the last result is held
    assign in_stall  = vld_reg[DEPTH-1] && out_stall;
    assign en        = !in_stall;
    assign out_valid = vld_reg[DEPTH-1];

    always_comb
    begin
        vld_next = vld_reg;
        if (en)
        begin
            vld_next = {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign ax_x = '{org: origin_x, rcp: recip_x, lo: lo_x, hi: hi_x};
    assign ax_y = '{org: origin_y, rcp: recip_y, lo: lo_y, hi: hi_y};
    assign ax_z = '{org: origin_z, rcp: recip_z, lo: lo_z, hi: hi_z};

    rbst_axis u_axis_x (
        .clk       (clk),
        .en        (en),
        .axis_in   (ax_x),
        .threshold (threshold),
        .slab      (slab_x)
    );

    rbst_axis u_axis_y (
        .clk       (clk),
        .en        (en),
        .axis_in   (ax_y),
        .threshold (threshold),
        .slab      (slab_y)
    );

    rbst_axis u_axis_z (
        .clk       (clk),
        .en        (en),
        .axis_in   (ax_z),
        .threshold (threshold),
        .slab      (slab_z)
    );

    rbst_merge u_merge (
        .clk    (clk),
        .en     (en),
        .slab_x (slab_x),
        .slab_y (slab_y),
        .slab_z (slab_z),
        .hit    (hit)
    );

endmodule

>>> src/rbst_cfg.sv
// ---------------------------------------------------------------------------
// rbst_cfg
// apb register file holding the parallel threshold
// ---------------------------------------------------------------------------
module rbst_cfg
    import rbst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [THR_W-1:0]   threshold
);

    logic [THR_W-1:0] threshold_reg;
    logic [THR_W-1:0] threshold_next;
    logic             wr_hit;

    assign wr_hit = psel && penable && pwrite && (paddr == THR_ADDR);

    always_comb
    begin
        threshold_next = threshold_reg;
        if (wr_hit)
        begin
            threshold_next = pwdata[THR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THR_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    assign prdata    = (paddr == THR_ADDR) ? {1'b0, threshold_reg} : '0;
    assign pready    = 1'b1;
    assign threshold = threshold_reg;

endmodule

>>> src/rbst_axis.sv
// ---------------------------------------------------------------------------
// rbst_axis
// three-stage slab computation for one axis: differences, products, ordering
// ---------------------------------------------------------------------------
module rbst_axis
    import rbst_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  rbst_axis_in_t    axis_in,
    input  logic [THR_W-1:0] threshold,
    output rbst_slab_t       slab
);

    // stage 1
    logic signed [DIFF_W-1:0] diff_lo_reg;
    logic signed [DIFF_W-1:0] diff_hi_reg;
    logic signed [DATA_W-1:0] rcp_reg;
    logic                     par_reg;
    logic                     inside_reg;
    logic        [DATA_W-1:0] mag;
    logic signed [DIFF_W-1:0] diff_lo_next;
    logic signed [DIFF_W-1:0] diff_hi_next;
    logic                     par_next;
    logic                     inside_next;

    // stage 2
    logic signed [T_W-1:0]    prod_lo_reg;
    logic signed [T_W-1:0]    prod_hi_reg;
    logic                     par2_reg;
    logic                     inside2_reg;
    logic signed [T_W:0]      prod_lo_full;
    logic signed [T_W:0]      prod_hi_full;

    // stage 3
    rbst_slab_t               slab_reg;
    rbst_slab_t               slab_next;

    // magnitude; the most negative value maps to 2^31 as unsigned
    assign mag = axis_in.rcp[DATA_W-1] ? (~axis_in.rcp + 32'd1) : axis_in.rcp;

    always_comb
    begin
        diff_lo_next = $signed({axis_in.lo[DATA_W-1], axis_in.lo})
                     - $signed({axis_in.org[DATA_W-1], axis_in.org});
        diff_hi_next = $signed({axis_in.hi[DATA_W-1], axis_in.hi})
                     - $signed({axis_in.org[DATA_W-1], axis_in.org});
        par_next     = (mag >= {1'b0, threshold});
        inside_next  = ($signed(axis_in.org) > $signed(axis_in.lo))
                    && ($signed(axis_in.org) < $signed(axis_in.hi));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_lo_reg <= diff_lo_next;
            diff_hi_reg <= diff_hi_next;
            rcp_reg     <= $signed(axis_in.rcp);
            par_reg     <= par_next;
            inside_reg  <= inside_next;
        end
    end

    // exact whenever the axis is not parallel, since then |rcp| < 2^31
    assign prod_lo_full = diff_lo_reg * rcp_reg;
    assign prod_hi_full = diff_hi_reg * rcp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_lo_reg <= prod_lo_full[T_W-1:0];
            prod_hi_reg <= prod_hi_full[T_W-1:0];
            par2_reg    <= par_reg;
            inside2_reg <= inside_reg;
        end
    end

    always_comb
    begin
        slab_next.miss = 1'b0;
        if (par2_reg)
        begin
            slab_next.near_t = T_NEG_INF;
            slab_next.far_t  = T_POS_INF;
            slab_next.miss   = !inside2_reg;
        end
        else if (prod_lo_reg > prod_hi_reg)
        begin
            slab_next.near_t = prod_hi_reg;
            slab_next.far_t  = prod_lo_reg;
        end
        else
        begin
            slab_next.near_t = prod_lo_reg;
            slab_next.far_t  = prod_hi_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            slab_reg <= slab_next;
        end
    end

    assign slab = slab_reg;

endmodule

>>> src/rbst_merge.sv
// ---------------------------------------------------------------------------
// rbst_merge
// intersects the three slabs and decides the hit in two stages
// ---------------------------------------------------------------------------
module rbst_merge
    import rbst_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  rbst_slab_t slab_x,
    input  rbst_slab_t slab_y,
    input  rbst_slab_t slab_z,
    output logic       hit
);

    logic signed [T_W-1:0] near_reg;
    logic signed [T_W-1:0] far_reg;
    logic                  miss_reg;
    logic                  hit_reg;
    logic signed [T_W-1:0] near_xy;
    logic signed [T_W-1:0] far_xy;
    logic signed [T_W-1:0] near_next;
    logic signed [T_W-1:0] far_next;
    logic                  hit_next;

    always_comb
    begin
        near_xy   = ($signed(slab_x.near_t) > $signed(slab_y.near_t))
                  ? $signed(slab_x.near_t) : $signed(slab_y.near_t);
        far_xy    = ($signed(slab_x.far_t) < $signed(slab_y.far_t))
                  ? $signed(slab_x.far_t) : $signed(slab_y.far_t);
        near_next = ($signed(slab_z.near_t) > near_xy) ? $signed(slab_z.near_t) : near_xy;
        far_next  = ($signed(slab_z.far_t) < far_xy) ? $signed(slab_z.far_t) : far_xy;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            near_reg <= near_next;
            far_reg  <= far_next;
            miss_reg <= slab_x.miss || slab_y.miss || slab_z.miss;
        end
    end

    // an empty or single-point interval or a box behind the origin misses
    assign hit_next = !miss_reg && (near_reg < far_reg) && !far_reg[T_W-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

>>> src/rbst_sva.sv
// ---------------------------------------------------------------------------
// rbst_sva
// port-level checks of the slab test, bound to the top level
// ---------------------------------------------------------------------------
`include "ray_box_slab_test_macros.svh"

module rbst_sva
    import rbst_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               hit,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata,
    input logic               pready
);

    logic cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready && (paddr == THR_ADDR);

    // a held result keeps its value
    `RBST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hit))

    // the input side backs up exactly when a result is held
    `RBST_ASSERT_NOW(a_stall_link, 1'b1, in_stall == (out_valid && out_stall))

    // with no result shown the input side is never held
    `RBST_ASSERT_NOW(a_no_valid_no_stall, !out_valid, !in_stall)

    // threshold write reads back, top bit cleared
    `RBST_ASSERT_NEXT(a_cfg_readback, cfg_wr && (paddr == THR_ADDR),
        (paddr != THR_ADDR) || (prdata == ($past(pwdata) & 32'h7fff_ffff))
        || (psel && penable && pwrite))

endmodule

bind ray_box_slab_test rbst_sva u_rbst_sva (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
);
